// ===== rtl/rase_pkg.sv =====
// Shared types, constants and helpers for the rotor angle and speed estimator.
// Used by the top level and by the two serial arithmetic units; depends on nothing.
`default_nettype none

package rase_pkg;

   // Field widths of the request, the response and the fixed-point format.
   localparam int ANGLE_W = 16;
   localparam int SPEED_W = 32;
   localparam int FRAC_W  = 16;
   localparam int TICK_W  = 32;

   // Serial multiplier: multiplicand width, multiplier digits and product width.
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 17;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

   // Serial divider: dividend and quotient width, divisor width.
   localparam int DIV_N_W   = 35;
   localparam int DIV_D_W   = 31;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   // Q16.16 constants for pi/3 and 2*pi.
   localparam int PI_3_Q16   = 68629;
   localparam int TWO_PI_Q16 = 411775;

   // Register file of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_DIR     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTS_PER_TURN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_ANGLE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_OFFSET    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_GAIN     = 3'd6;

   // Sensor modes.
   localparam logic [1:0] MODE_NONE     = 2'd0;
   localparam logic [1:0] MODE_HALL     = 2'd1;
   localparam logic [1:0] MODE_ABSOLUTE = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   // One request: the Hall bits and the absolute encoder count of one tick.
   typedef struct packed {
      logic [2:0]         hall_pattern;
      logic [ANGLE_W-1:0] raw_count;
   } rase_req_type;

   // One response: angle, filtered speed and presence flag.
   typedef struct packed {
      logic [ANGLE_W-1:0]        angle;
      logic signed [SPEED_W-1:0] speed;
      logic                      present;
   } rase_rsp_type;

   // Electrical angle at the start of each Hall sector.
   function automatic logic [ANGLE_W-1:0] sector_angle(input logic [2:0] pattern);
      logic [ANGLE_W-1:0] angle;
      unique case (pattern)
         3'd2:    angle = 16'd10923;
         3'd3:    angle = 16'd21845;
         3'd4:    angle = 16'd32768;
         3'd5:    angle = 16'd43690;
         3'd6:    angle = 16'd54613;
         default: angle = 16'd0;
      endcase
      return angle;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rase_serial_mul.sv =====
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// Depends on rase_pkg for its operand and product widths.
`default_nettype none

module rase_serial_mul import rase_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] multiplicand,
   input  logic [MUL_B_W-1:0] multiplier,
   output logic               done,
   output logic [MUL_P_W-1:0] product
);

   localparam logic [MUL_CNT_W-1:0] STEPS = MUL_CNT_W'(MUL_B_W);

   logic [MUL_A_W:0]     acc_ff;
   logic [MUL_B_W-1:0]   low_ff;
   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_CNT_W-1:0] count_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [MUL_A_W:0]     sum_in;

   // Add the multiplicand when the current multiplier bit is set.
   assign sum_in = acc_ff + (low_ff[0] ? {1'b0, a_ff} : '0);

   // The multiplier and the partial product shift right one bit per step.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= multiplicand;
         low_ff <= multiplier;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= {1'b0, sum_in[MUL_A_W:1]};
         low_ff <= {sum_in[0], low_ff[MUL_B_W-1:1]};
      end
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && (count_ff == MUL_CNT_W'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= STEPS;
         end else if (busy_ff) begin
            count_ff <= count_ff - MUL_CNT_W'(1);
            if (count_ff == MUL_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = {acc_ff[MUL_A_W-1:0], low_ff};

endmodule

`default_nettype wire

// ===== rtl/rase_serial_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on rase_pkg for its dividend, divisor and counter widths.
`default_nettype none

module rase_serial_div import rase_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   localparam logic [DIV_CNT_W-1:0] STEPS = DIV_CNT_W'(DIV_N_W);

   logic [DIV_N_W-1:0]   shift_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_D_W-1:0]   divisor_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 fits;
   logic [DIV_D_W-1:0]   rem_in;

   // Bring down the next dividend bit and try to subtract the divisor.
   assign trial  = {rem_ff, shift_ff[DIV_N_W-1]};
   assign diff   = trial - {1'b0, divisor_ff};
   assign fits   = trial >= {1'b0, divisor_ff};
   assign rem_in = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];

   // Dividend bits leave at the top while quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff   <= dividend;
         divisor_ff <= divisor;
         rem_ff     <= '0;
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[DIV_N_W-2:0], fits};
         rem_ff   <= rem_in;
      end
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && (count_ff == DIV_CNT_W'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= STEPS;
         end else if (busy_ff) begin
            count_ff <= count_ff - DIV_CNT_W'(1);
            if (count_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

`default_nettype wire

// ===== rtl/rotor_angle_speed_estimator_core.sv =====
// Top level of the rotor angle and speed estimator: sequencer, state and ports.
// Depends on rase_pkg, rase_serial_mul and rase_serial_div.
//
// Each request carries one control tick's Hall pattern and absolute encoder
// count. Each request yields exactly one response with the electrical angle,
// the filtered Q16.16 speed and the presence flag. The block works on one
// request at a time and is ready for the next as soon as the previous response
// sits in the output register. A request in mode none or reserved, or a Hall
// tick without a sector change, uses neither arithmetic unit. The time of a
// Hall sector change or an absolute-mode tick is set by the shared multiplier,
// which retires one multiplier bit per cycle over 17 steps, and by the shared
// divider, which produces one quotient bit per cycle over 35 steps. A Hall
// change uses one product, one quotient and the filter product. An absolute
// tick uses two products and two quotients, or one quotient when counts per
// turn is zero. A stalled response holds the block in its last state until the
// output register frees. Configuration writes are always taken and must only be
// issued while no request is in flight.
`default_nettype none

module rotor_angle_speed_estimator_core import rase_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rase_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rase_rsp_type           rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_HMUL  = 4'd1;
   localparam logic [3:0] ST_HDIV  = 4'd2;
   localparam logic [3:0] ST_ADIV  = 4'd3;
   localparam logic [3:0] ST_AANG  = 4'd4;
   localparam logic [3:0] ST_AMUL  = 4'd5;
   localparam logic [3:0] ST_ADIV2 = 4'd6;
   localparam logic [3:0] ST_FDIFF = 4'd7;
   localparam logic [3:0] ST_FMUL  = 4'd8;
   localparam logic [3:0] ST_FSUM  = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   // Hall patterns with all sensors low or all high are not sectors.
   localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
   localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

   localparam logic [DIV_N_W-1:0] HALL_DIVIDEND = DIV_N_W'(PI_3_Q16) << FRAC_W;
   localparam logic [SPEED_W-1:0] SPEED_MAX     = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic [SPEED_W-1:0] SPEED_MIN     = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam int                 STEP_W        = MUL_P_W + 1 - FRAC_W;

   // Configuration registers.
   logic [1:0]            mode_ff;
   logic                  reverse_ff;
   logic [CSR_DATA_W-1:0] counts_per_turn_ff;
   logic                  invert_ff;
   logic [ANGLE_W-1:0]    offset_ff;
   logic [ANGLE_W-1:0]    tick_period_ff;
   logic [CSR_DATA_W-1:0] gain_ff;

   // Estimator state.
   logic [2:0]                last_sector_ff;
   logic [TICK_W-1:0]         tick_count_ff;
   logic signed [SPEED_W-1:0] filtered_ff;
   logic [ANGLE_W-1:0]        previous_angle_ff;
   logic [ANGLE_W-1:0]        angle_reg_ff;
   logic signed [SPEED_W-1:0] speed_reg_ff;
   logic                      present_reg_ff;

   // Sequencer and working registers.
   logic [3:0]                state_ff;
   logic [3:0]                state_in;
   logic [ANGLE_W-1:0]        na_ff;
   logic signed [SPEED_W-1:0] inst_ff;
   logic                      neg_ff;
   logic signed [STEP_W-1:0]  step_ff;
   logic                      rsp_valid_ff;
   rase_rsp_type              rsp_payload_ff;

   // Arithmetic unit connections.
   logic               mul_start;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic               mul_done;
   logic [MUL_P_W-1:0] mul_p;
   logic               div_start;
   logic [DIV_N_W-1:0] div_dividend;
   logic [DIV_D_W-1:0] div_divisor;
   logic               div_done;
   logic [DIV_N_W-1:0] div_q;

   // Derived values.
   logic                      req_fire;
   logic                      out_free;
   logic [ANGLE_W-1:0]        dt;
   logic [TICK_W-1:0]         tick_sat;
   logic                      hall_change;
   logic                      hall_filter;
   logic [DIV_D_W-1:0]        period_prod_sat;
   logic [SPEED_W-1:0]        hall_pos;
   logic signed [SPEED_W-1:0] hall_inst;
   logic signed [SPEED_W-1:0] abs_inst;
   logic [ANGLE_W-1:0]        na_inv;
   logic [ANGLE_W-1:0]        na_off;
   logic signed [ANGLE_W:0]   delta_raw;
   logic signed [ANGLE_W:0]   delta;
   logic [ANGLE_W:0]          delta_neg;
   logic [SPEED_W:0]          diff;
   logic [SPEED_W:0]          diff_mag;
   logic [MUL_P_W:0]          prod_signed;
   logic [SPEED_W+3:0]        sum;
   logic signed [SPEED_W-1:0] sum_sat;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;

   // A zero tick period is taken as one.
   assign dt = (tick_period_ff == '0) ? ANGLE_W'(1) : tick_period_ff;

   // Hall tick count saturates and a sector change needs a new valid pattern.
   assign tick_sat    = (tick_count_ff == '1) ? tick_count_ff : tick_count_ff + TICK_W'(1);
   assign hall_change = (req_payload.hall_pattern != last_sector_ff)
                        && (req_payload.hall_pattern != HALL_ALL_LOW)
                        && (req_payload.hall_pattern != HALL_ALL_HIGH);
   assign hall_filter = hall_change && (tick_sat != '0);

   // Period product saturates to the largest positive 32-bit value.
   assign period_prod_sat = (|mul_p[MUL_P_W-1:DIV_D_W]) ? '1 : mul_p[DIV_D_W-1:0];

   // Hall speed sample: saturated quotient, negated for reverse direction.
   assign hall_pos  = (|div_q[DIV_N_W-1:SPEED_W-1]) ? SPEED_MAX
                      : {1'b0, div_q[SPEED_W-2:0]};
   assign hall_inst = reverse_ff ? -$signed(hall_pos) : $signed(hall_pos);

   // Absolute speed sample: quotient magnitude with the delta's sign, saturated.
   always_comb begin
      if (neg_ff) begin
         if ((|div_q[DIV_N_W-1:SPEED_W]) || (div_q[SPEED_W-1] && (|div_q[SPEED_W-2:0]))) begin
            abs_inst = $signed(SPEED_MIN);
         end else begin
            abs_inst = -$signed(div_q[SPEED_W-1:0]);
         end
      end else begin
         if (|div_q[DIV_N_W-1:SPEED_W-1]) begin
            abs_inst = $signed(SPEED_MAX);
         end else begin
            abs_inst = $signed(div_q[SPEED_W-1:0]);
         end
      end
   end

   // Absolute angle: inversion, offset, then the wrapped change since last tick.
   assign na_inv    = invert_ff ? ANGLE_W'(0) - na_ff : na_ff;
   assign na_off    = na_inv + offset_ff;
   assign delta_raw = $signed({1'b0, na_off}) - $signed({1'b0, previous_angle_ff});
   always_comb begin
      if (delta_raw > $signed(17'sd32768)) begin
         delta = delta_raw - $signed(17'h10000);
      end else if (delta_raw < -$signed(17'sd32768)) begin
         delta = delta_raw + $signed(17'h10000);
      end else begin
         delta = delta_raw;
      end
   end
   assign delta_neg = -delta;

   // Filter error and its magnitude for the unsigned multiplier.
   assign diff     = {inst_ff[SPEED_W-1], inst_ff} - {filtered_ff[SPEED_W-1], filtered_ff};
   assign diff_mag = diff[SPEED_W] ? -diff : diff;

   // Signed filter product; dropping the fraction bits floors it.
   assign prod_signed = neg_ff ? -{1'b0, mul_p} : {1'b0, mul_p};

   // Filter update with saturation to the signed 32-bit range.
   assign sum = {{4{filtered_ff[SPEED_W-1]}}, filtered_ff}
                + {step_ff[STEP_W-1], step_ff};
   always_comb begin
      if ((sum[SPEED_W+3:SPEED_W-1] == '0) || (sum[SPEED_W+3:SPEED_W-1] == '1)) begin
         sum_sat = $signed(sum[SPEED_W-1:0]);
      end else if (sum[SPEED_W+3]) begin
         sum_sat = $signed(SPEED_MIN);
      end else begin
         sum_sat = $signed(SPEED_MAX);
      end
   end

   // Sequencer: next state and arithmetic unit launches.
   always_comb begin
      state_in     = state_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (mode_ff)
                  MODE_HALL: begin
                     if (hall_filter) begin
                        mul_start = 1'b1;
                        mul_a     = MUL_A_W'(tick_sat);
                        mul_b     = MUL_B_W'(dt);
                        state_in  = ST_HMUL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  MODE_ABSOLUTE: begin
                     if (counts_per_turn_ff != '0) begin
                        div_start    = 1'b1;
                        div_dividend = DIV_N_W'({req_payload.raw_count, {FRAC_W{1'b0}}});
                        div_divisor  = DIV_D_W'(counts_per_turn_ff);
                        state_in     = ST_ADIV;
                     end else begin
                        state_in = ST_AANG;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_HMUL: begin
            if (mul_done) begin
               div_start    = 1'b1;
               div_dividend = HALL_DIVIDEND;
               div_divisor  = period_prod_sat;
               state_in     = ST_HDIV;
            end
         end
         ST_HDIV: begin
            if (div_done) begin
               state_in = ST_FDIFF;
            end
         end
         ST_ADIV: begin
            if (div_done) begin
               state_in = ST_AANG;
            end
         end
         ST_AANG: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(TWO_PI_Q16);
            mul_b     = MUL_B_W'(delta[ANGLE_W] ? delta_neg[ANGLE_W-1:0]
                                                : delta[ANGLE_W-1:0]);
            state_in  = ST_AMUL;
         end
         ST_AMUL: begin
            if (mul_done) begin
               div_start    = 1'b1;
               div_dividend = mul_p[DIV_N_W-1:0];
               div_divisor  = DIV_D_W'(dt);
               state_in     = ST_ADIV2;
            end
         end
         ST_ADIV2: begin
            if (div_done) begin
               state_in = ST_FDIFF;
            end
         end
         ST_FDIFF: begin
            mul_start = 1'b1;
            mul_a     = diff_mag;
            mul_b     = gain_ff;
            state_in  = ST_FMUL;
         end
         ST_FMUL: begin
            if (mul_done) begin
               state_in = ST_FSUM;
            end
         end
         ST_FSUM: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_NONE;
         reverse_ff         <= 1'b0;
         counts_per_turn_ff <= '0;
         invert_ff          <= 1'b0;
         offset_ff          <= '0;
         tick_period_ff     <= ANGLE_W'(3277);
         gain_ff            <= CSR_DATA_W'(8192);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SENSOR_MODE:     mode_ff            <= csr_data[1:0];
            CSR_REVERSE_DIR:     reverse_ff         <= csr_data[0];
            CSR_COUNTS_PER_TURN: counts_per_turn_ff <= csr_data;
            CSR_INVERT_ANGLE:    invert_ff          <= csr_data[0];
            CSR_ANGLE_OFFSET:    offset_ff          <= csr_data[ANGLE_W-1:0];
            CSR_TICK_PERIOD:     tick_period_ff     <= csr_data[ANGLE_W-1:0];
            CSR_FILTER_GAIN:     gain_ff            <= csr_data;
            default: ;
         endcase
      end
   end

   // Estimator state and sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         last_sector_ff    <= '0;
         tick_count_ff     <= '0;
         filtered_ff       <= '0;
         previous_angle_ff <= '0;
         angle_reg_ff      <= '0;
         speed_reg_ff      <= '0;
         present_reg_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (mode_ff == MODE_HALL)) begin
                  tick_count_ff <= hall_change ? '0 : tick_sat;
                  if (hall_change) begin
                     last_sector_ff <= req_payload.hall_pattern;
                     angle_reg_ff   <= sector_angle(req_payload.hall_pattern);
                  end
                  if (!hall_filter) begin
                     speed_reg_ff <= filtered_ff;
                  end
               end
               if (req_fire && (mode_ff == MODE_ABSOLUTE)
                   && (req_payload.raw_count != '0)) begin
                  present_reg_ff <= 1'b1;
               end
            end
            ST_AANG: begin
               previous_angle_ff <= na_off;
               angle_reg_ff      <= na_off;
            end
            ST_FSUM: begin
               filtered_ff  <= sum_sat;
               speed_reg_ff <= sum_sat;
            end
            default: ;
         endcase
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               na_ff <= '0;
            end
         end
         ST_HDIV: begin
            if (div_done) begin
               inst_ff <= hall_inst;
            end
         end
         ST_ADIV: begin
            if (div_done) begin
               na_ff <= div_q[ANGLE_W-1:0];
            end
         end
         ST_AANG:  neg_ff <= delta[ANGLE_W];
         ST_ADIV2: begin
            if (div_done) begin
               inst_ff <= abs_inst;
            end
         end
         ST_FDIFF: neg_ff <= diff[SPEED_W];
         ST_FMUL: begin
            if (mul_done) begin
               step_ff <= $signed(prod_signed[MUL_P_W:FRAC_W]);
            end
         end
         default: ;
      endcase
   end

   // Response register: loads when the slot is free, clears when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_payload_ff.angle   <= angle_reg_ff;
         rsp_payload_ff.speed   <= speed_reg_ff;
         rsp_payload_ff.present <= present_reg_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Shared arithmetic units.
   rase_serial_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .done         (mul_done),
      .product      (mul_p)
   );

   rase_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

endmodule

`default_nettype wire
